[hdl/spc_pkg.sv]
// Package for the segment/plane crossing block: widths, register indexes, item types.
// No dependencies.
`timescale 1ns / 1ps
package spc_pkg;
  localparam int CoordW = 32;
  localparam int NormW  = 18;
  localparam int EpsW   = 31;
  localparam int DistW  = 54;
  localparam int MagW   = 54;
  localparam int TW     = 16;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegCenterX = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCenterZ = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNormalX = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNormalY = 3'd4;
  localparam logic [CfgIdxW-1:0] RegNormalZ = 3'd5;
  localparam logic [CfgIdxW-1:0] RegEps     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegValid   = 3'd7;

  typedef struct packed {
    logic signed [CoordW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  } seg_t;

  typedef struct packed {
    logic                     hit;
    logic signed [CoordW-1:0] point_x, point_y, point_z;
    logic [TW-1:0]            t_fraction;
  } res_t;

  typedef struct packed {
    logic signed [CoordW-1:0] c_x, c_y, c_z;
    logic signed [NormW-1:0]  n_x, n_y, n_z;
    logic [EpsW-1:0]          eps;
    logic                     valid;
  } plane_t;

  // Classified item handed from the front to the back part.
  typedef struct packed {
    seg_t          seg;
    logic          ok;
    logic [MagW-1:0] ma;
    logic [MagW-1:0] sum;
  } job_t;
endpackage

[hdl/spc_if.sv]
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
interface spc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/segment_plane_crossing_top.sv]
// Segment/plane crossing test: top level with config registers, front, queue, back.
// Depends on spc_pkg, spc_if, spc_front, spc_fifo, spc_back.
//
// Usage: segments enter on seg_in (valid/ready, a_x..b_z in Q16.16), and one
// result leaves on res_out per segment (hit, point_x/y/z, t_fraction; all
// zero on a miss). The plane is set through cfg_we_i/cfg_idx_i/cfg_data_i
// while the block is idle; unknown indexes are ignored.
// Throughput is one segment per cycle while res_out is not stalled. The path
// holds three front stages (products, sums, classification), the queue,
// seventeen divider stages, one multiply stage and the output register.
// The divider produces one quotient bit per stage.
// Reset clears the plane registers (plane invalid) and empties all stages.
// When the receiver stalls, the back part fills, then the queue, then the
// front; seg_in.ready drops only once all of them are full.
`timescale 1ns / 1ps
module segment_plane_crossing_top #(
  parameter int QueueDepth = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [spc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                 cfg_data_i,
  spc_if.sink                         seg_in,
  spc_if.source                       res_out
);
  import spc_pkg::*;

  plane_t pl_q;
  job_t fj, qj;
  logic fv, fr, qv, qr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCenterX: pl_q.c_x <= cfg_data_i;
        RegCenterY: pl_q.c_y <= cfg_data_i;
        RegCenterZ: pl_q.c_z <= cfg_data_i;
        RegNormalX: pl_q.n_x <= cfg_data_i[NormW-1:0];
        RegNormalY: pl_q.n_y <= cfg_data_i[NormW-1:0];
        RegNormalZ: pl_q.n_z <= cfg_data_i[NormW-1:0];
        RegEps:     pl_q.eps <= cfg_data_i[EpsW-1:0];
        RegValid:   pl_q.valid <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  spc_front u_front (
    .clk_i, .rst_ni, .plane_i(pl_q),
    .seg_i(seg_in.data), .valid_i(seg_in.valid), .ready_o(seg_in.ready),
    .job_o(fj), .valid_o(fv), .ready_i(fr)
  );

  spc_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .wdata_i(fj), .wvalid_i(fv), .wready_o(fr),
    .rdata_o(qj), .rvalid_o(qv), .rready_i(qr)
  );

  spc_back u_back (
    .clk_i, .rst_ni,
    .job_i(qj), .valid_i(qv), .ready_o(qr),
    .res_o(res_out.data), .valid_o(res_out.valid), .ready_i(res_out.ready)
  );
endmodule

[hdl/spc_front.sv]
// Front part: distance products, sums and classification, as a 3-stage pipeline.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spc_pkg::plane_t plane_i,
  input  spc_pkg::seg_t   seg_i,
  input  logic            valid_i,
  output logic            ready_o,
  output spc_pkg::job_t   job_o,
  output logic            valid_o,
  input  logic            ready_i
);
  import spc_pkg::*;

  logic [2:0] v_q, v_d;
  logic adv0, adv1, adv2;
  seg_t s1_q, s2_q, s3_q;
  logic signed [51:0] pa_q [3], pb_q [3];
  logic signed [DistW-1:0] da_q, db_q;
  logic ok3_q;
  logic [MagW-1:0] ma_q, sum_q;
  logic signed [CoordW:0] dfa [3], dfb [3];
  logic signed [CoordW-1:0] ca [3], pa [3], pb [3];
  logic signed [NormW-1:0] nn [3];
  logic [MagW-1:0] ma_c, mb_c, lim;

  assign adv2 = !v_q[2] || ready_i;
  assign adv1 = !v_q[1] || adv2;
  assign adv0 = !v_q[0] || adv1;
  assign ready_o = adv0;
  assign valid_o = v_q[2];

  assign ca = '{plane_i.c_x, plane_i.c_y, plane_i.c_z};
  assign nn = '{plane_i.n_x, plane_i.n_y, plane_i.n_z};
  assign pa = '{seg_i.a_x, seg_i.a_y, seg_i.a_z};
  assign pb = '{seg_i.b_x, seg_i.b_y, seg_i.b_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dfa[i] = 33'(pa[i]) - 33'(ca[i]);
      dfb[i] = 33'(pb[i]) - 33'(ca[i]);
    end
  end

  always_comb begin
    v_d = v_q;
    if (adv2) v_d[2] = v_q[1];
    if (adv1) v_d[1] = v_q[0];
    if (adv0) v_d[0] = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ma_c = da_q < 0 ? MagW'(-da_q) : MagW'(da_q);
  assign mb_c = db_q < 0 ? MagW'(-db_q) : MagW'(db_q);
  assign lim  = MagW'({plane_i.eps, 16'b0});

  always_ff @(posedge clk_i) begin
    if (adv0 && valid_i) begin
      s1_q <= seg_i;
      for (int i = 0; i < 3; i++) begin
        pa_q[i] <= 52'(dfa[i] * nn[i]);
        pb_q[i] <= 52'(dfb[i] * nn[i]);
      end
    end
    if (adv1 && v_q[0]) begin
      s2_q <= s1_q;
      da_q <= DistW'(pa_q[0]) + DistW'(pa_q[1]) + DistW'(pa_q[2]);
      db_q <= DistW'(pb_q[0]) + DistW'(pb_q[1]) + DistW'(pb_q[2]);
    end
    if (adv2 && v_q[1]) begin
      s3_q  <= s2_q;
      ma_q  <= ma_c;
      sum_q <= ma_c + mb_c;
      ok3_q <= plane_i.valid && !((da_q > 0 && db_q > 0) || (da_q < 0 && db_q < 0))
               && !(ma_c < lim) && !(mb_c < lim) && (mb_c != '0) && (ma_c != '0);
    end
  end

  assign job_o = '{seg: s3_q, ok: ok3_q, ma: ma_q, sum: sum_q};
endmodule

[hdl/spc_fifo.sv]
// Short queue of classified items between the front and back parts.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spc_pkg::job_t wdata_i,
  input  logic          wvalid_i,
  output logic          wready_o,
  output spc_pkg::job_t rdata_o,
  output logic          rvalid_o,
  input  logic          rready_i
);
  import spc_pkg::*;
  localparam int PtrW = $clog2(Depth);

  job_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [PtrW:0] cnt_q;
  logic wr, rd;

  assign wready_o = cnt_q != (PtrW+1)'(Depth);
  assign rvalid_o = cnt_q != '0;
  assign wr = wvalid_i && wready_o;
  assign rd = rvalid_o && rready_i;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(wr) - (PtrW+1)'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wdata_i;
  end
endmodule

[hdl/spc_back.sv]
// Back part: pipelined restoring divider for t, then the point interpolation.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spc_pkg::job_t job_i,
  input  logic          valid_i,
  output logic          ready_o,
  output spc_pkg::res_t res_o,
  output logic          valid_o,
  input  logic          ready_i
);
  import spc_pkg::*;
  // Stage 0 takes the integer bit, stages 1..16 one quotient bit each,
  // then one multiply stage and one output stage.
  localparam int NDiv = TW + 1;
  localparam int NSt  = NDiv + 2;

  logic [NSt-1:0] v_q;
  logic [NSt-1:0] adv;
  seg_t sg_q [NSt-1];
  logic ok_q [NDiv];
  logic [MagW:0] r_q [NDiv];
  logic [MagW-1:0] sm_q [NDiv];
  logic [TW:0] q_q [NDiv];
  logic signed [49:0] st_q [3];
  logic okm_q;
  logic [TW-1:0] tm_q;
  res_t out_q;
  logic [MagW:0] r_sh [NDiv];
  logic signed [CoordW:0] dif [3];
  logic signed [CoordW-1:0] av [3], bv [3];
  logic signed [CoordW-1:0] pt [3];

  always_comb begin
    adv[NSt-1] = !v_q[NSt-1] || ready_i;
    for (int i = NSt - 2; i >= 0; i--) adv[i] = !v_q[i] || adv[i+1];
  end
  assign ready_o = adv[0];
  assign valid_o = v_q[NSt-1];
  assign res_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = NSt - 1; i > 0; i--) if (adv[i]) v_q[i] <= v_q[i-1];
      if (adv[0]) v_q[0] <= valid_i;
    end
  end

  always_comb begin
    r_sh[0] = '0;
    for (int i = 1; i < NDiv; i++) r_sh[i] = {r_q[i-1][MagW-1:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && valid_i) begin
      sg_q[0] <= job_i.seg;
      ok_q[0] <= job_i.ok;
      sm_q[0] <= job_i.sum;
      if (job_i.ma >= job_i.sum) begin
        r_q[0] <= {1'b0, job_i.ma - job_i.sum};
        q_q[0] <= (TW+1)'(1);
      end else begin
        r_q[0] <= {1'b0, job_i.ma};
        q_q[0] <= '0;
      end
    end
    for (int i = 1; i < NDiv; i++) begin
      if (adv[i] && v_q[i-1]) begin
        sg_q[i] <= sg_q[i-1];
        ok_q[i] <= ok_q[i-1];
        sm_q[i] <= sm_q[i-1];
        if (r_sh[i] >= {1'b0, sm_q[i-1]}) begin
          r_q[i] <= r_sh[i] - {1'b0, sm_q[i-1]};
          q_q[i] <= {q_q[i-1][TW-1:0], 1'b1};
        end else begin
          r_q[i] <= r_sh[i];
          q_q[i] <= {q_q[i-1][TW-1:0], 1'b0};
        end
      end
    end
    if (adv[NDiv] && v_q[NDiv-1]) begin
      sg_q[NDiv] <= sg_q[NDiv-1];
      okm_q <= ok_q[NDiv-1] && (q_q[NDiv-1] != '0) && !q_q[NDiv-1][TW];
      tm_q  <= q_q[NDiv-1][TW-1:0];
      for (int k = 0; k < 3; k++) st_q[k] <= 50'(dif[k] * $signed({1'b0, q_q[NDiv-1][TW-1:0]}));
    end
    if (adv[NSt-1] && v_q[NSt-2]) begin
      out_q.hit        <= okm_q;
      out_q.point_x    <= okm_q ? pt[0] : '0;
      out_q.point_y    <= okm_q ? pt[1] : '0;
      out_q.point_z    <= okm_q ? pt[2] : '0;
      out_q.t_fraction <= okm_q ? tm_q : '0;
    end
  end

  assign av = '{sg_q[NDiv-1].a_x, sg_q[NDiv-1].a_y, sg_q[NDiv-1].a_z};
  assign bv = '{sg_q[NDiv-1].b_x, sg_q[NDiv-1].b_y, sg_q[NDiv-1].b_z};
  always_comb begin
    for (int k = 0; k < 3; k++) dif[k] = 33'(bv[k]) - 33'(av[k]);
  end
  assign pt[0] = sg_q[NDiv].a_x + CoordW'(st_q[0] >>> 16);
  assign pt[1] = sg_q[NDiv].a_y + CoordW'(st_q[1] >>> 16);
  assign pt[2] = sg_q[NDiv].a_z + CoordW'(st_q[2] >>> 16);
endmodule

[hdl/spc_checker.sv]
// Port-level checker for the crossing block, bound to the top level.
// Depends on spc_pkg.
`timescale 1ns / 1ps
module spc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid,
  input logic          out_ready,
  input spc_pkg::res_t out_data
);
  import spc_pkg::*;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.hit |-> out_data.point_x == '0 && out_data.point_y == '0
      && out_data.point_z == '0 && out_data.t_fraction == '0)
    else $error("miss result carries nonzero fields");

  a_hit_t: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.hit |-> out_data.t_fraction != '0)
    else $error("hit with zero t");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid)
    else $error("result valid right after reset");
endmodule

bind segment_plane_crossing_top spc_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
);

[sim/segment_plane_crossing_top_tb.sv]
// Testbench for segment_plane_crossing_top: directed and random segments against several planes.
// Depends on spc_pkg, spc_if and the block itself; results are checked against a built-in predictor.
`timescale 1ns / 1ps
module segment_plane_crossing_top_tb;
  import spc_pkg::*;

  localparam int ResetCycles = 9;
  localparam int Latency     = 24;
  localparam int LimitCycles = 1000000;
  localparam int PlanePhases = 8;
  localparam int PhaseItems  = 205;

  class crossing_scoreboard;
    plane_t plane;
    res_t   expected_q[$];

    function new();
      plane = '0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
      case (idx)
        RegCenterX: plane.c_x = val;
        RegCenterY: plane.c_y = val;
        RegCenterZ: plane.c_z = val;
        RegNormalX: plane.n_x = val[NormW-1:0];
        RegNormalY: plane.n_y = val[NormW-1:0];
        RegNormalZ: plane.n_z = val[NormW-1:0];
        RegEps:     plane.eps = val[EpsW-1:0];
        RegValid:   plane.valid = val[0];
        default: ;
      endcase
    endfunction

    function longint plane_distance(logic signed [31:0] px, py, pz);
      longint acc;
      acc = (longint'(px) - longint'(plane.c_x)) * longint'(plane.n_x);
      acc += (longint'(py) - longint'(plane.c_y)) * longint'(plane.n_y);
      acc += (longint'(pz) - longint'(plane.c_z)) * longint'(plane.n_z);
      return acc;
    endfunction

    function logic [31:0] step_along(logic signed [31:0] a, b, longint t);
      longint d;
      longint p;
      d = longint'(b) - longint'(a);
      p = longint'(a) + ((d * t) >>> 16);
      return p[31:0];
    endfunction

    function res_t crossing(seg_t s);
      res_t r;
      longint da, db;
      logic [127:0] ma, mb, lim, sum, tq;
      r = '0;
      if (!plane.valid) return r;
      da = plane_distance(s.a_x, s.a_y, s.a_z);
      db = plane_distance(s.b_x, s.b_y, s.b_z);
      if ((da > 0 && db > 0) || (da < 0 && db < 0)) return r;
      ma = (da < 0) ? -da : da;
      mb = (db < 0) ? -db : db;
      lim = {97'd0, plane.eps} << 16;
      if (ma < lim || mb < lim) return r;
      sum = ma + mb;
      if (sum == 0) return r;
      tq = (ma << 16) / sum;
      if (tq == 0 || tq >= 65536) return r;
      r.hit = 1'b1;
      r.point_x = step_along(s.a_x, s.b_x, longint'(tq[16:0]));
      r.point_y = step_along(s.a_y, s.b_y, longint'(tq[16:0]));
      r.point_z = step_along(s.a_z, s.b_z, longint'(tq[16:0]));
      r.t_fraction = tq[15:0];
      return r;
    endfunction

    function void note_request(seg_t s);
      expected_q.push_back(crossing(s));
    endfunction

    function bit check_result(res_t got, output string msg);
      res_t want;
      msg = "";
      if (expected_q.size() == 0) begin
        msg = "result arrived with nothing expected";
        return 1'b0;
      end
      want = expected_q.pop_front();
      if (got.hit !== want.hit)
        msg = {msg, $sformatf(" hit %0b/%0b", got.hit, want.hit)};
      if (got.point_x !== want.point_x)
        msg = {msg, $sformatf(" point_x %h/%h", got.point_x, want.point_x)};
      if (got.point_y !== want.point_y)
        msg = {msg, $sformatf(" point_y %h/%h", got.point_y, want.point_y)};
      if (got.point_z !== want.point_z)
        msg = {msg, $sformatf(" point_z %h/%h", got.point_z, want.point_z)};
      if (got.t_fraction !== want.t_fraction)
        msg = {msg, $sformatf(" t_fraction %h/%h", got.t_fraction, want.t_fraction)};
      return msg == "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  int errors;
  crossing_scoreboard sb;

  spc_if #(.T(seg_t)) seg_if ();
  spc_if #(.T(res_t)) res_if ();

  segment_plane_crossing_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .seg_in(seg_if),
    .res_out(res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t:%s", $realtime, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && seg_if.valid && seg_if.ready) sb.note_request(seg_if.data);
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (!sb.check_result(res_if.data, msg)) report(msg);
    end
  end

  initial begin
    int run;
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      run = $urandom_range(99) < 10 ? $urandom_range(200, 50) : $urandom_range(8, 1);
      res_if.ready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_plane(logic [31:0] cx, cy, cz, nx, ny, nz, eps, vld);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
    write_reg(RegCenterZ, cz);
    write_reg(RegNormalX, nx);
    write_reg(RegNormalY, ny);
    write_reg(RegNormalZ, nz);
    write_reg(RegEps, eps);
    write_reg(RegValid, vld);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_segment(seg_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      seg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seg_if.data <= s;
    seg_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!seg_if.ready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    seg_if.valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  function automatic seg_t axis_seg(logic [31:0] ax, bx);
    seg_t s;
    s = '0;
    s.a_x = ax;
    s.b_x = bx;
    s.a_y = $urandom;
    s.b_y = $urandom;
    s.a_z = $urandom;
    s.b_z = $urandom;
    return s;
  endfunction

  function automatic logic [31:0] near_coord(logic [31:0] c);
    int sh;
    sh = $urandom_range(30, 4);
    return c + ($signed($urandom) >>> (31 - sh));
  endfunction

  function automatic seg_t random_seg();
    seg_t s;
    if ($urandom_range(99) < 30) begin
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else begin
      s.a_x = near_coord(sb.plane.c_x);
      s.a_y = near_coord(sb.plane.c_y);
      s.a_z = near_coord(sb.plane.c_z);
      s.b_x = near_coord(sb.plane.c_x);
      s.b_y = near_coord(sb.plane.c_y);
      s.b_z = near_coord(sb.plane.c_z);
    end
    return s;
  endfunction

  task automatic random_plane(int kind);
    logic [31:0] nx, ny, nz, eps;
    nx = $urandom;
    ny = $urandom;
    nz = $urandom;
    eps = $urandom_range(99) < 50 ? 0 : $urandom_range(3);
    case (kind)
      0: write_plane($urandom, $urandom, $urandom, nx, ny, nz, eps, 0);
      1: write_plane($urandom, $urandom, $urandom, 32'h10000, 0, 0, 0, 1);
      2: write_plane($urandom, $urandom, $urandom, nx, ny, nz, eps, 1);
      3: write_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                     32'h1ffff, 32'h20000, 32'h1ffff, 0, 1);
      4: write_plane(32'h80000000, 32'h7fffffff, 32'h80000000,
                     32'h20000, 32'h1ffff, 32'h20000, 1, 1);
      5: write_plane($urandom, $urandom, $urandom, nx, ny, nz, 32'h7fffffff, 1);
      6: write_plane(0, 0, 0, 32'hb505, 32'hffff4afb, 0, eps, 1);
      default: write_plane($urandom, $urandom, $urandom, nx, ny, nz,
                           $urandom_range(255), 1);
    endcase
  endtask

  initial begin
    seg_t s;
    errors = 0;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    seg_if.valid = 1'b0;
    seg_if.data = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_segment(axis_seg(32'hffff0000, 32'h00010000));
    wait_idle();
    write_plane(0, 0, 0, 32'h10000, 0, 0, 0, 1);
    send_segment(axis_seg(32'hffff0000, 32'h00010000));
    send_segment(axis_seg(32'hffff0000, 32'h00030000));
    send_segment(axis_seg(32'h00010000, 32'h00020000));
    send_segment(axis_seg(32'hfffe0000, 32'hffff0000));
    send_segment(axis_seg(0, 0));
    send_segment(axis_seg(32'hffff0000, 0));
    send_segment(axis_seg(0, 32'h00010000));
    send_segment(axis_seg(32'hffffffff, 32'h7fffffff));
    send_segment(axis_seg(32'h80000000, 32'h7fffffff));
    send_segment(axis_seg(32'h7fffffff, 32'h80000000));
    s = {6{32'h80000000}};
    s.b_x = 32'h7fffffff;
    s.b_y = 32'h7fffffff;
    s.b_z = 32'h7fffffff;
    send_segment(s);
    wait_idle();
    write_plane(0, 0, 0, 32'h10000, 0, 0, 1, 1);
    send_segment(axis_seg(32'hffff0001, 32'h00010000));
    send_segment(axis_seg(32'hffff0000, 32'h00010000));
    send_segment(axis_seg(32'hffff0000, 32'h0000ffff));
    wait_idle();

    for (int ph = 0; ph < PlanePhases; ph++) begin
      random_plane(ph);
      for (int k = 0; k < PhaseItems; k++) send_segment(random_seg());
      wait_idle();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
